### hdl/glyph_alpha_blit_unit_macros.svh
// ----------------------------------------------------------------------------
// Glyph alpha blit: assertion macros
// Concurrent assertion wrappers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef GLYPH_ALPHA_BLIT_UNIT_MACROS_SVH
`define GLYPH_ALPHA_BLIT_UNIT_MACROS_SVH

`ifndef SYNTH
`define GAB_ASSERT(lbl, ck, rs, prop) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) \
    else $error("glyph blit assertion failed");
`define GAB_ASSERT_ALWAYS(lbl, ck, prop) \
  lbl: assert property (@(posedge ck) prop) \
    else $error("glyph blit assertion failed");
`else
`define GAB_ASSERT(lbl, ck, rs, prop)
`define GAB_ASSERT_ALWAYS(lbl, ck, prop)
`endif

`endif

### hdl/gab_pkg.sv
// ----------------------------------------------------------------------------
// Glyph alpha blit: package
// Widths, limits, codes and the types shared between the blit modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gab_pkg;

  localparam int MAX_FRAME_WIDTH  = 4096;
  localparam int MAX_FRAME_HEIGHT = 4096;
  localparam int MAX_GLYPH_SIZE   = 256;

  localparam int COORD_W    = 13;  // signed origin
  localparam int GLYPH_W    = 9;
  localparam int FRAME_W    = 13;
  localparam int PITCH_W    = 14;
  localparam int ADDR_W     = 26;
  localparam int CH_W       = 8;
  localparam int BLEND_W    = 2 * CH_W;
  localparam int DX_W       = COORD_W + 1;
  localparam int X_W        = $clog2(MAX_FRAME_WIDTH);
  localparam int Y_W        = $clog2(MAX_FRAME_HEIGHT);
  localparam int X3_W       = X_W + 2;
  localparam int ROW_OFF_W  = Y_W + PITCH_W;
  localparam int ADDR_SUM_W = ROW_OFF_W + 1;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 14;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_LINE_PITCH   = 2'd2,
    REG_UNUSED       = 2'd3
  } reg_idx_t;

  localparam logic MODE_HEADER = 1'b0;
  localparam logic MODE_ALPHA  = 1'b1;

  localparam logic [FRAME_W-1:0] FRAME_WIDTH_RST  = 13'd640;
  localparam logic [FRAME_W-1:0] FRAME_HEIGHT_RST = 13'd480;
  localparam logic [PITCH_W-1:0] LINE_PITCH_RST   = 14'd1920;

  typedef struct packed {
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] b;
  } rgb_t;

  // in-frame pixel handed from the walker to the blend pipeline
  typedef struct packed {
    logic            valid;
    logic [X_W-1:0]  x;
    logic [Y_W-1:0]  y;
    rgb_t            fg;
    rgb_t            bg;
    logic [CH_W-1:0] alpha;
  } job_t;

endpackage

`default_nettype wire

### hdl/gab_if.sv
// ----------------------------------------------------------------------------
// Glyph alpha blit: channel interfaces
// Valid/ready channels for glyph items in and pixel writes out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface gab_in_if import gab_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      mode;
  logic signed [COORD_W-1:0] origin_x;
  logic signed [COORD_W-1:0] origin_y;
  logic [GLYPH_W-1:0]        glyph_width;
  logic [GLYPH_W-1:0]        glyph_rows;
  logic [CH_W-1:0]           fg_red;
  logic [CH_W-1:0]           fg_green;
  logic [CH_W-1:0]           fg_blue;
  logic [CH_W-1:0]           bg_red;
  logic [CH_W-1:0]           bg_green;
  logic [CH_W-1:0]           bg_blue;
  logic [CH_W-1:0]           alpha;

  modport source (
    output valid, mode, origin_x, origin_y, glyph_width, glyph_rows,
           fg_red, fg_green, fg_blue, bg_red, bg_green, bg_blue, alpha,
    input  ready
  );
  modport sink (
    input  valid, mode, origin_x, origin_y, glyph_width, glyph_rows,
           fg_red, fg_green, fg_blue, bg_red, bg_green, bg_blue, alpha,
    output ready
  );
endinterface

interface gab_out_if import gab_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] byte_address;
  logic [CH_W-1:0]   red;
  logic [CH_W-1:0]   green;
  logic [CH_W-1:0]   blue;

  modport source (output valid, byte_address, red, green, blue, input ready);
  modport sink   (input valid, byte_address, red, green, blue, output ready);
endinterface

`default_nettype wire

### hdl/gab_ctrl.sv
// ----------------------------------------------------------------------------
// Glyph alpha blit: glyph walker
// Latches glyph headers, steps the column/row counters per alpha byte,
// clips against the frame and registers in-frame pixels as jobs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gab_ctrl import gab_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  gab_in_if.sink                  in_ch,
  input  wire logic [FRAME_W-1:0] frame_width,
  input  wire logic [FRAME_W-1:0] frame_height,
  input  wire logic               job_take,
  output job_t                    job
);

  logic signed [COORD_W-1:0] base_x;
  logic signed [COORD_W-1:0] base_y;
  logic [GLYPH_W-1:0]        width_latched;
  logic [GLYPH_W-1:0]        rows_latched;
  rgb_t                      fore_colour;
  rgb_t                      back_colour;
  logic [GLYPH_W-1:0]        col_counter;
  logic [GLYPH_W-1:0]        row_counter;

  logic                      job_valid;
  logic [X_W-1:0]            job_x;
  logic [Y_W-1:0]            job_y;
  rgb_t                      job_fg;
  rgb_t                      job_bg;
  logic [CH_W-1:0]           job_alpha;

  logic                      accept;
  logic                      active;
  logic                      hit;
  logic [GLYPH_W-1:0]        col_inc;
  logic [DX_W-1:0]           dx;
  logic [DX_W-1:0]           dy;
  logic [FRAME_W-1:0]        fw_sat;
  logic [FRAME_W-1:0]        fh_sat;
  logic [GLYPH_W-1:0]        width_sat;
  logic [GLYPH_W-1:0]        rows_sat;

  assign in_ch.ready = !job_valid || job_take;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    fw_sat = (frame_width > FRAME_W'(MAX_FRAME_WIDTH)) ?
             FRAME_W'(MAX_FRAME_WIDTH) : frame_width;
    fh_sat = (frame_height > FRAME_W'(MAX_FRAME_HEIGHT)) ?
             FRAME_W'(MAX_FRAME_HEIGHT) : frame_height;
    width_sat = (in_ch.glyph_width > GLYPH_W'(MAX_GLYPH_SIZE)) ?
                GLYPH_W'(MAX_GLYPH_SIZE) : in_ch.glyph_width;
    rows_sat  = (in_ch.glyph_rows > GLYPH_W'(MAX_GLYPH_SIZE)) ?
                GLYPH_W'(MAX_GLYPH_SIZE) : in_ch.glyph_rows;

    active  = (width_latched != '0) && (row_counter < rows_latched);
    col_inc = col_counter + GLYPH_W'(1);

    // signed origin plus unsigned counter, one bit wider
    dx = {base_x[COORD_W-1], base_x} + {{(DX_W-GLYPH_W){1'b0}}, col_counter};
    dy = {base_y[COORD_W-1], base_y} + {{(DX_W-GLYPH_W){1'b0}}, row_counter};

    hit = active
       && !dx[DX_W-1] && (dx < {{(DX_W-FRAME_W){1'b0}}, fw_sat})
       && !dy[DX_W-1] && (dy < {{(DX_W-FRAME_W){1'b0}}, fh_sat});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_x        <= '0;
      base_y        <= '0;
      width_latched <= '0;
      rows_latched  <= '0;
      fore_colour   <= '0;
      back_colour   <= '0;
      col_counter   <= '0;
      row_counter   <= '0;
    end else if (accept) begin
      if (in_ch.mode == MODE_HEADER) begin
        base_x        <= in_ch.origin_x;
        base_y        <= in_ch.origin_y;
        width_latched <= width_sat;
        rows_latched  <= rows_sat;
        fore_colour   <= '{in_ch.fg_red, in_ch.fg_green, in_ch.fg_blue};
        back_colour   <= '{in_ch.bg_red, in_ch.bg_green, in_ch.bg_blue};
        col_counter   <= '0;
        row_counter   <= '0;
      end else if (active) begin
        if (col_inc >= width_latched) begin
          col_counter <= '0;
          row_counter <= row_counter + GLYPH_W'(1);
        end else begin
          col_counter <= col_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (accept) begin
      job_valid <= (in_ch.mode == MODE_ALPHA) && hit;
    end else if (job_take) begin
      job_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      job_x     <= dx[X_W-1:0];
      job_y     <= dy[Y_W-1:0];
      job_fg    <= fore_colour;
      job_bg    <= back_colour;
      job_alpha <= in_ch.alpha;
    end
  end

  assign job = '{job_valid, job_x, job_y, job_fg, job_bg, job_alpha};

endmodule

`default_nettype wire

### hdl/gab_calc.sv
// ----------------------------------------------------------------------------
// Glyph alpha blit: address and blend pipeline
// Two register stages: products, then address sum and divide by 255.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gab_calc import gab_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire job_t               job,
  input  wire logic [PITCH_W-1:0] line_pitch,
  output logic                    job_take,
  gab_out_if.source               out_ch
);

  logic                  s2_valid;
  logic [ROW_OFF_W-1:0]  s2_row_off;
  logic [X3_W-1:0]       s2_x3;
  logic [BLEND_W-1:0]    s2_sum_r;
  logic [BLEND_W-1:0]    s2_sum_g;
  logic [BLEND_W-1:0]    s2_sum_b;

  logic                  out_valid;
  logic [ADDR_W-1:0]     out_addr;
  rgb_t                  out_rgb;

  logic                  take_out;
  logic                  s2_ready;
  logic [CH_W-1:0]       inv_alpha;
  logic [ROW_OFF_W-1:0]  row_off;
  logic [X3_W-1:0]       x3;
  logic [ADDR_SUM_W-1:0] addr_sum;

  function automatic logic [BLEND_W-1:0] blend_sum(
    input logic [CH_W-1:0] f,
    input logic [CH_W-1:0] b,
    input logic [CH_W-1:0] a,
    input logic [CH_W-1:0] na
  );
    logic [BLEND_W-1:0] pf;
    logic [BLEND_W-1:0] pb;
    pf = BLEND_W'(f) * BLEND_W'(a);
    pb = BLEND_W'(b) * BLEND_W'(na);
    return pf + pb;  // at most 255*255, no carry out
  endfunction

  // exact s/255 for s up to 255*255
  function automatic logic [CH_W-1:0] div255(input logic [BLEND_W-1:0] s);
    logic [BLEND_W:0] t;
    t = {1'b0, s} + (BLEND_W+1)'(1) + {{(CH_W+1){1'b0}}, s[BLEND_W-1:CH_W]};
    return t[BLEND_W-1:CH_W];
  endfunction

  assign take_out = !out_valid || out_ch.ready;
  assign s2_ready = !s2_valid || take_out;
  assign job_take = s2_ready;

  always_comb begin
    inv_alpha = ~job.alpha;
    row_off   = ROW_OFF_W'(job.y) * ROW_OFF_W'(line_pitch);
    x3        = {1'b0, job.x, 1'b0} + {2'b00, job.x};
    addr_sum  = {1'b0, s2_row_off} + {{(ADDR_SUM_W-X3_W){1'b0}}, s2_x3};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s2_ready) begin
        s2_valid <= job.valid;
      end
      if (take_out) begin
        out_valid <= s2_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready) begin
      s2_row_off <= row_off;
      s2_x3      <= x3;
      s2_sum_r   <= blend_sum(job.fg.r, job.bg.r, job.alpha, inv_alpha);
      s2_sum_g   <= blend_sum(job.fg.g, job.bg.g, job.alpha, inv_alpha);
      s2_sum_b   <= blend_sum(job.fg.b, job.bg.b, job.alpha, inv_alpha);
    end
    if (take_out) begin
      out_addr  <= addr_sum[ADDR_W-1:0];
      out_rgb.r <= div255(s2_sum_r);
      out_rgb.g <= div255(s2_sum_g);
      out_rgb.b <= div255(s2_sum_b);
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.byte_address = out_addr;
  assign out_ch.red          = out_rgb.r;
  assign out_ch.green        = out_rgb.g;
  assign out_ch.blue         = out_rgb.b;

endmodule

`default_nettype wire

### hdl/glyph_alpha_blit_unit.sv
// ----------------------------------------------------------------------------
// Glyph alpha blit unit: top level
// Composites glyph coverage bytes into an RGB24 pitched framebuffer.
// ----------------------------------------------------------------------------
// Takes one transaction per clock, headers and alpha bytes alike, and keeps
// doing so while output is stalled until its three internal registers fill.
// A pixel write for each taken in-frame alpha byte passes through the walker
// register, the multiply register, then the address/divide result
// register. Headers, clipped pixels and alpha bytes past the end of the
// glyph produce no write. The frame size and pitch registers are written
// through the cfg port and must only change while nothing is in flight.
`timescale 1ns / 1ps
`default_nettype none

`include "glyph_alpha_blit_unit_macros.svh"

module glyph_alpha_blit_unit import gab_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  gab_in_if.sink                     in_ch,
  gab_out_if.source                  out_ch
);

  logic [FRAME_W-1:0] frame_width;
  logic [FRAME_W-1:0] frame_height;
  logic [PITCH_W-1:0] line_pitch;

  job_t               job;
  logic               job_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
      line_pitch   <= LINE_PITCH_RST;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[FRAME_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[FRAME_W-1:0];
        REG_LINE_PITCH:   line_pitch   <= cfg_data[PITCH_W-1:0];
        default: ;
      endcase
    end
  end

  gab_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_ch        (in_ch),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .job_take     (job_take),
    .job          (job)
  );

  gab_calc u_calc (
    .clk        (clk),
    .rst        (rst),
    .job        (job),
    .line_pitch (line_pitch),
    .job_take   (job_take),
    .out_ch     (out_ch)
  );

  // a stalled job stays put until the pipeline takes it
  `GAB_ASSERT(a_job_held, clk, rst, (job.valid && !job_take) |=> job.valid)
  // headers never turn into pixel jobs
  `GAB_ASSERT(a_hdr_no_job, clk, rst, (in_ch.valid && in_ch.ready && in_ch.mode == MODE_HEADER) |=> !job.valid)
  // input only back-pressures when a job is blocked
  `GAB_ASSERT(a_ready_cause, clk, rst, !in_ch.ready |-> (job.valid && !job_take))
  // no write is offered straight out of reset
  `GAB_ASSERT_ALWAYS(a_rst_quiet, clk, $past(rst) |-> !out_ch.valid)

endmodule

`default_nettype wire

### sim/glyph_alpha_blit_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph alpha blit unit: testbench
// Streams glyph headers and coverage bytes into the blit unit, with random
// idle gaps on the input and random back-pressure on the output. A behavioural
// copy of the walker, clipper and blender predicts the writes not typed
// into the directed table, and the pixel writes that come out are checked
// field by field, in order. A short table of directed glyphs runs first, then
// randomised glyphs over several frame and pitch settings and their extremes.
// ----------------------------------------------------------------------------

module glyph_alpha_blit_unit_test;
  import gab_pkg::*;

  localparam int IDLE_PCT       = 18;
  localparam int SETTLE_CYCLES  = 8;
  localparam int QUIET_LIMIT    = 4000;
  localparam int DIR_ROWS       = 25;
  localparam int NUM_PHASES     = 6;
  localparam int MAX_GLYPH_SEND = 48;

  typedef struct {
    logic                      mode;
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic [GLYPH_W-1:0]        glyph_width;
    logic [GLYPH_W-1:0]        glyph_rows;
    rgb_t                      fg;
    rgb_t                      bg;
    logic [CH_W-1:0]           alpha;
  } glyph_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [CH_W-1:0]   red;
    logic [CH_W-1:0]   green;
    logic [CH_W-1:0]   blue;
  } pixel_write_t;

  // how a table row's result is known: from the predictor, or typed in
  typedef enum {ROW_PREDICTED, ROW_SILENT, ROW_PIXEL} row_kind_t;

  typedef struct {
    row_kind_t    kind;
    glyph_item_t  item;
    pixel_write_t px;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  reg_idx_t              cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  gab_in_if  in_ch ();
  gab_out_if out_ch ();

  glyph_alpha_blit_unit uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor copy of the registers and walker state
  logic [FRAME_W-1:0]        cfg_frame_w;
  logic [FRAME_W-1:0]        cfg_frame_h;
  logic [PITCH_W-1:0]        cfg_pitch;
  logic signed [COORD_W-1:0] glyph_x;
  logic signed [COORD_W-1:0] glyph_y;
  logic [GLYPH_W-1:0]        span_w;
  logic [GLYPH_W-1:0]        span_h;
  rgb_t                      fore;
  rgb_t                      back;
  logic [GLYPH_W-1:0]        pix_col;
  logic [GLYPH_W-1:0]        pix_row;

  pixel_write_t pending_writes[$];
  int           mismatch_count = 0;
  int           quiet_cycles = 0;
  int           items_sent = 0;
  bit           calm_stretch = 1'b0;

  // transaction currently offered on the input channel
  glyph_item_t  cur_item;
  row_kind_t    cur_kind;
  pixel_write_t cur_px;

  stim_row_t dir_table [DIR_ROWS];
  int        phase_len [NUM_PHASES] = '{160, 50, 160, 175, 160, 215};

  function automatic logic [CH_W-1:0] blend_channel(int f, int b, int a);
    return CH_W'((f * a + b * (255 - a)) / 255);
  endfunction

  // Advances the walker for one transaction; returns 1 with the pixel write
  // when an in-frame pixel is produced.
  function automatic bit predict_pixel_write(input glyph_item_t it,
                                             output pixel_write_t px);
    int dx, dy, fw, fh;
    px = '0;
    if (it.mode == MODE_HEADER) begin
      glyph_x = it.origin_x;
      glyph_y = it.origin_y;
      span_w  = (it.glyph_width > MAX_GLYPH_SIZE) ? GLYPH_W'(MAX_GLYPH_SIZE)
                                                   : it.glyph_width;
      span_h  = (it.glyph_rows > MAX_GLYPH_SIZE) ? GLYPH_W'(MAX_GLYPH_SIZE)
                                                  : it.glyph_rows;
      fore    = it.fg;
      back    = it.bg;
      pix_col = '0;
      pix_row = '0;
      return 1'b0;
    end
    if (span_w == 0 || pix_row >= span_h)
      return 1'b0;
    dx = int'(glyph_x) + int'(pix_col);
    dy = int'(glyph_y) + int'(pix_row);
    pix_col = pix_col + 1'b1;
    if (pix_col >= span_w) begin
      pix_col = '0;
      pix_row = pix_row + 1'b1;
    end
    fw = (cfg_frame_w > MAX_FRAME_WIDTH) ? MAX_FRAME_WIDTH : int'(cfg_frame_w);
    fh = (cfg_frame_h > MAX_FRAME_HEIGHT) ? MAX_FRAME_HEIGHT : int'(cfg_frame_h);
    if (dx < 0 || dy < 0 || dx >= fw || dy >= fh)
      return 1'b0;
    px.addr  = ADDR_W'(dy * int'(cfg_pitch) + dx * 3);
    px.red   = blend_channel(fore.r, back.r, it.alpha);
    px.green = blend_channel(fore.g, back.g, it.alpha);
    px.blue  = blend_channel(fore.b, back.b, it.alpha);
    return 1'b1;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : monitor
    pixel_write_t predicted;
    pixel_write_t want;
    bit           fires;
    if (rst) begin
      cfg_frame_w = FRAME_WIDTH_RST;
      cfg_frame_h = FRAME_HEIGHT_RST;
      cfg_pitch   = LINE_PITCH_RST;
      glyph_x = '0;
      glyph_y = '0;
      span_w  = '0;
      span_h  = '0;
      fore    = '0;
      back    = '0;
      pix_col = '0;
      pix_row = '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_FRAME_WIDTH:  cfg_frame_w = cfg_data[FRAME_W-1:0];
          REG_FRAME_HEIGHT: cfg_frame_h = cfg_data[FRAME_W-1:0];
          REG_LINE_PITCH:   cfg_pitch   = cfg_data[PITCH_W-1:0];
          default: ;
        endcase
      end
      quiet_cycles = quiet_cycles + 1;
      if (in_ch.valid && in_ch.ready) begin
        quiet_cycles = 0;
        fires = predict_pixel_write(cur_item, predicted);
        case (cur_kind)
          ROW_PIXEL:     pending_writes.push_back(cur_px);
          ROW_PREDICTED: if (fires) pending_writes.push_back(predicted);
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        quiet_cycles = 0;
        if (pending_writes.size() == 0) begin
          $error("unexpected pixel write, address %0d", out_ch.byte_address);
          mismatch_count++;
        end else begin
          want = pending_writes.pop_front();
          check_field("byte_address", want.addr, out_ch.byte_address);
          check_field("red", want.red, out_ch.red);
          check_field("green", want.green, out_ch.green);
          check_field("blue", want.blue, out_ch.blue);
        end
      end
    end
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready = !rst && (calm_stretch || $urandom_range(99) >= IDLE_PCT);
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT)
      @(posedge clk);
    $display("Some tests failed");
    $finish;
  end

  function automatic glyph_item_t header_item(int ox, int oy, int gw, int gr,
                                              logic [23:0] fg, logic [23:0] bg);
    glyph_item_t it;
    it = '{default: '0};
    it.mode        = MODE_HEADER;
    it.origin_x    = ox[COORD_W-1:0];
    it.origin_y    = oy[COORD_W-1:0];
    it.glyph_width = gw[GLYPH_W-1:0];
    it.glyph_rows  = gr[GLYPH_W-1:0];
    it.fg          = fg;
    it.bg          = bg;
    return it;
  endfunction

  function automatic glyph_item_t alpha_item(int a);
    glyph_item_t it;
    it = '{default: '0};
    it.mode  = MODE_ALPHA;
    it.alpha = a[CH_W-1:0];
    return it;
  endfunction

  // every field random; header fields on alpha transactions and the reverse
  // must be ignored by the block
  function automatic glyph_item_t noise_item();
    glyph_item_t it;
    it.mode        = 1'($urandom_range(1));
    it.origin_x    = COORD_W'($urandom_range(8191));
    it.origin_y    = COORD_W'($urandom_range(8191));
    it.glyph_width = GLYPH_W'($urandom_range(511));
    it.glyph_rows  = GLYPH_W'($urandom_range(511));
    it.fg          = 24'($urandom_range(24'hFFFFFF));
    it.bg          = 24'($urandom_range(24'hFFFFFF));
    it.alpha       = CH_W'($urandom_range(255));
    return it;
  endfunction

  task automatic send_item(input glyph_item_t it, input row_kind_t kind,
                           input pixel_write_t px);
    while (!calm_stretch && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    cur_item = it;
    cur_kind = kind;
    cur_px   = px;
    in_ch.mode        = it.mode;
    in_ch.origin_x    = it.origin_x;
    in_ch.origin_y    = it.origin_y;
    in_ch.glyph_width = it.glyph_width;
    in_ch.glyph_rows  = it.glyph_rows;
    in_ch.fg_red      = it.fg.r;
    in_ch.fg_green    = it.fg.g;
    in_ch.fg_blue     = it.fg.b;
    in_ch.bg_red      = it.bg.r;
    in_ch.bg_green    = it.bg.g;
    in_ch.bg_blue     = it.bg.b;
    in_ch.alpha       = it.alpha;
    in_ch.valid       = 1'b1;
    @(posedge clk);
    while (!in_ch.ready)
      @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_for_writes();
    in_ch.valid = 1'b0;
    while (pending_writes.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // One random glyph: a header, then its coverage bytes. Large glyphs are
  // cut short, a few are truncated early and some carry surplus bytes.
  task automatic send_glyph();
    glyph_item_t it;
    int          w, h, sw, sh, fw_eff, fh_eff, ox, oy, pixels, extra;
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 3) begin
      w = 0;
      h = $urandom_range(511);
    end else if (roll < 6) begin
      w = $urandom_range(1, 511);
      h = 0;
    end else if (roll < 12) begin
      w = $urandom_range(511);
      h = $urandom_range(511);
    end else begin
      w = $urandom_range(1, 12);
      h = $urandom_range(1, 8);
    end
    sw = (w > MAX_GLYPH_SIZE) ? MAX_GLYPH_SIZE : w;
    sh = (h > MAX_GLYPH_SIZE) ? MAX_GLYPH_SIZE : h;
    fw_eff = (cfg_frame_w > MAX_FRAME_WIDTH) ? MAX_FRAME_WIDTH : int'(cfg_frame_w);
    fh_eff = (cfg_frame_h > MAX_FRAME_HEIGHT) ? MAX_FRAME_HEIGHT : int'(cfg_frame_h);
    if ($urandom_range(99) < 25) begin
      ox = int'($urandom_range(8191)) - 4096;
      oy = int'($urandom_range(8191)) - 4096;
    end else begin
      // straddle the frame so that edges clip
      ox = int'($urandom_range(fw_eff + sw)) - sw;
      oy = int'($urandom_range(fh_eff + sh)) - sh;
      if (ox > 4095) ox = 4095;
      if (oy > 4095) oy = 4095;
    end
    it = noise_item();
    it.mode        = MODE_HEADER;
    it.origin_x    = ox[COORD_W-1:0];
    it.origin_y    = oy[COORD_W-1:0];
    it.glyph_width = w[GLYPH_W-1:0];
    it.glyph_rows  = h[GLYPH_W-1:0];
    send_item(it, ROW_PREDICTED, '0);
    items_sent++;
    pixels = sw * sh;
    if (pixels > MAX_GLYPH_SEND)
      pixels = $urandom_range(1, MAX_GLYPH_SEND);
    else if ($urandom_range(99) < 8)
      pixels = $urandom_range(pixels);
    extra = ($urandom_range(99) < 15) ? $urandom_range(1, 3) : 0;
    for (int n = 0; n < pixels + extra; n++) begin
      it = noise_item();
      it.mode = MODE_ALPHA;
      roll = $urandom_range(99);
      if (roll < 10)
        it.alpha = '0;
      else if (roll < 20)
        it.alpha = '1;
      send_item(it, ROW_PREDICTED, '0);
      if (n < pixels)
        items_sent++;
    end
    if ($urandom_range(99) < 2)
      wait_for_writes();
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] w_data, h_data, p_data;
    int                    target;
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = REG_FRAME_WIDTH;
    cfg_data  = '0;
    cur_item  = '{default: '0};
    cur_kind  = ROW_SILENT;
    cur_px    = '0;
    in_ch.valid       = 1'b0;
    in_ch.mode        = MODE_HEADER;
    in_ch.origin_x    = '0;
    in_ch.origin_y    = '0;
    in_ch.glyph_width = '0;
    in_ch.glyph_rows  = '0;
    in_ch.fg_red      = '0;
    in_ch.fg_green    = '0;
    in_ch.fg_blue     = '0;
    in_ch.bg_red      = '0;
    in_ch.bg_green    = '0;
    in_ch.bg_blue     = '0;
    in_ch.alpha       = '0;

    // reset frame: 640 x 480, pitch 1920
    dir_table = '{
      '{ROW_SILENT, alpha_item(7), '0},                    // nothing latched yet
      '{ROW_SILENT, header_item(0, 0, 2, 2, 24'hFFFFFF, 24'h000000), '0},
      '{ROW_PIXEL,  alpha_item(255), {26'd0, 8'd255, 8'd255, 8'd255}},
      '{ROW_PIXEL,  alpha_item(0), {26'd3, 8'd0, 8'd0, 8'd0}},
      '{ROW_PIXEL,  alpha_item(128), {26'd1920, 8'd128, 8'd128, 8'd128}},
      '{ROW_PIXEL,  alpha_item(1), {26'd1923, 8'd1, 8'd1, 8'd1}},
      '{ROW_SILENT, alpha_item(77), '0},                   // surplus byte
      '{ROW_SILENT, header_item(-4096, -4096, 511, 511, 24'h000000, 24'hFFFFFF), '0},
      '{ROW_SILENT, alpha_item(255), '0},
      '{ROW_SILENT, header_item(4095, 4095, 256, 256, 24'hAA550F, 24'h123456), '0},
      '{ROW_SILENT, alpha_item(200), '0},
      '{ROW_SILENT, header_item(-1, 0, 3, 1, 24'h102030, 24'hF0E0D0), '0},
      '{ROW_SILENT, alpha_item(9), '0},                    // left of frame
      '{ROW_PIXEL,  alpha_item(0), {26'd0, 8'hF0, 8'hE0, 8'hD0}},
      '{ROW_PIXEL,  alpha_item(255), {26'd3, 8'h10, 8'h20, 8'h30}},
      '{ROW_SILENT, header_item(638, 479, 4, 2, 24'hFF0080, 24'h00FF7F), '0},
      '{ROW_PREDICTED, alpha_item(200), '0},
      '{ROW_PREDICTED, alpha_item(55), '0},
      '{ROW_PREDICTED, alpha_item(90), '0},                // right edge
      '{ROW_PREDICTED, alpha_item(13), '0},
      '{ROW_PREDICTED, alpha_item(250), '0},               // below frame
      '{ROW_SILENT, header_item(10, 10, 0, 5, 24'h808080, 24'h404040), '0},
      '{ROW_SILENT, alpha_item(66), '0},
      '{ROW_SILENT, header_item(10, 10, 5, 0, 24'h808080, 24'h404040), '0},
      '{ROW_SILENT, alpha_item(99), '0}
    };

    repeat (2) @(negedge clk);
    rst = 1'b0;

    foreach (dir_table[i])
      send_item(dir_table[i].item, dir_table[i].kind, dir_table[i].px);

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_for_writes();
      repeat (SETTLE_CYCLES) @(negedge clk);
      case (p)
        0: begin
          // beyond the frame maximum; bit 13 of the size registers dropped
          w_data = '1;
          h_data = '1;
          p_data = '1;
        end
        1: begin
          w_data = '0;
          h_data = '0;
          p_data = '0;
        end
        2: begin
          w_data = 14'd17;
          h_data = 14'd9;
          p_data = 14'd60;
        end
        3: begin
          w_data = CFG_DATA_W'($urandom_range(16, MAX_FRAME_WIDTH));
          h_data = CFG_DATA_W'($urandom_range(16, MAX_FRAME_HEIGHT));
          p_data = CFG_DATA_W'(int'(w_data) * 3 + int'($urandom_range(64)));
        end
        4: begin
          w_data = CFG_DATA_W'(MAX_FRAME_WIDTH);
          h_data = CFG_DATA_W'(MAX_FRAME_HEIGHT);
          p_data = 14'd12288;
        end
        default: begin
          w_data = CFG_DATA_W'($urandom_range(16383));
          h_data = CFG_DATA_W'($urandom_range(16383));
          p_data = CFG_DATA_W'($urandom_range(16383));
        end
      endcase
      write_reg(REG_FRAME_WIDTH, w_data);
      write_reg(REG_FRAME_HEIGHT, h_data);
      write_reg(REG_LINE_PITCH, p_data);
      write_reg(REG_UNUSED, CFG_DATA_W'($urandom_range(16383)));
      calm_stretch = (p == 3);
      target = items_sent + phase_len[p];
      while (items_sent < target)
        send_glyph();
    end
    calm_stretch = 1'b0;

    wait_for_writes();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && pending_writes.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
